// ===== rtl/lfei_pkg.sv =====
package lfei_pkg;

    // Sequence numbers wrap at this modulus on a skip (power of two)
    localparam int unsigned SEQ_MODULUS = 512;

    localparam int unsigned SEQ_W   = 9;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned PER_W   = 16;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BURST    = 2'd2;

    localparam logic [KIND_W-1:0] ERR_NONE = 3'd0;
    localparam logic [KIND_W-1:0] ERR_CRC  = 3'd1;
    localparam logic [KIND_W-1:0] ERR_DROP = 3'd2;
    localparam logic [KIND_W-1:0] ERR_DUP  = 3'd3;
    localparam logic [KIND_W-1:0] ERR_SKIP = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_KIND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_OPEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN    = 3'd4;

    localparam logic [CRC_W-1:0] CRC_INVERT = 16'hFFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KIND_W-1:0] error_kind;
        logic [PER_W-1:0]  period;
        logic [CNT_W-1:0]  win_open;
        logic [CNT_W-1:0]  win_len;
    } cfg_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_in;
        logic [CRC_W-1:0] crc_in;
        logic             restart_count;
    } in_beat_t;

    typedef struct packed {
        logic              drop;
        logic [SEQ_W-1:0]  seq_out;
        logic [CRC_W-1:0]  crc_out;
        logic [KIND_W-1:0] applied_error;
    } out_beat_t;

endpackage

// ===== rtl/lfei_in_if.sv =====
interface lfei_in_if
    import lfei_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] seq_in;
    logic [CRC_W-1:0] crc_in;
    logic             restart_count;

    modport source (output valid, output seq_in, output crc_in, output restart_count,
                    input ready);
    modport sink   (input valid, input seq_in, input crc_in, input restart_count,
                    output ready);
endinterface

// ===== rtl/lfei_out_if.sv =====
interface lfei_out_if
    import lfei_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              drop;
    logic [SEQ_W-1:0]  seq_out;
    logic [CRC_W-1:0]  crc_out;
    logic [KIND_W-1:0] applied_error;

    modport source (output valid, output drop, output seq_out, output crc_out,
                    output applied_error, input ready);
    modport sink   (input valid, input drop, input seq_out, input crc_out,
                    input applied_error, output ready);
endinterface

// ===== rtl/link_flit_error_injector.sv =====
// channel   dir  payload                                      accepted when
// flit_in   in   seq_in, crc_in, restart_count                valid & ready
// flit_out  out  drop, seq_out, crc_out, applied_error        valid & ready
// cfg       in   cfg_index, cfg_wdata                         cfg_we
//
// One beat per cycle sustained while the result is not stalled.
// Input register, then policy/apply logic, then result register.
// Policy counters update when a beat moves into the result register; last sequence too, unless duplicated.
// rst_n clears counters, config to defaults, and both stage valids.
// A stalled result holds the input stage; the input still takes a beat while it is empty.
module link_flit_error_injector
    import lfei_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    lfei_in_if.sink               flit_in,
    lfei_out_if.source            flit_out
);

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_beat_t  in_beat_reg;
    logic      out_valid_reg;
    out_beat_t out_beat_reg;

    logic      advance;
    logic      fire;
    out_beat_t result;

    assign advance       = in_valid_reg && (!out_valid_reg || flit_out.ready);
    assign flit_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_OFF;
            cfg_reg.error_kind <= ERR_NONE;
            cfg_reg.period     <= PER_W'(1);
            cfg_reg.win_open   <= '0;
            cfg_reg.win_len    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:       cfg_reg.mode       <= cfg_wdata[MODE_W-1:0];
                CFG_ERROR_KIND: cfg_reg.error_kind <= cfg_wdata[KIND_W-1:0];
                CFG_PERIOD:     cfg_reg.period     <= cfg_wdata[PER_W-1:0];
                CFG_WIN_OPEN:   cfg_reg.win_open   <= cfg_wdata[CNT_W-1:0];
                CFG_WIN_LEN:    cfg_reg.win_len    <= cfg_wdata[CNT_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (flit_in.ready)
            begin
                in_valid_reg <= flit_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (flit_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (flit_in.ready && flit_in.valid)
        begin
            in_beat_reg.seq_in        <= flit_in.seq_in;
            in_beat_reg.crc_in        <= flit_in.crc_in;
            in_beat_reg.restart_count <= flit_in.restart_count;
        end
        if (advance)
        begin
            out_beat_reg <= result;
        end
    end

    lfei_policy u_policy (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .restart (in_beat_reg.restart_count),
        .cfg     (cfg_reg),
        .fire    (fire)
    );

    lfei_apply u_apply (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .fire       (fire),
        .error_kind (cfg_reg.error_kind),
        .beat       (in_beat_reg),
        .result     (result)
    );

    assign flit_out.valid         = out_valid_reg;
    assign flit_out.drop          = out_beat_reg.drop;
    assign flit_out.seq_out       = out_beat_reg.seq_out;
    assign flit_out.crc_out       = out_beat_reg.crc_out;
    assign flit_out.applied_error = out_beat_reg.applied_error;

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not filled after advance");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !flit_out.ready)
        |=> (in_valid_reg && $stable(in_beat_reg)))
        else $error("input stage lost a beat during output stall");

    a_off_applies_none: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cfg_reg.mode == MODE_OFF))
        |=> (out_beat_reg.applied_error == ERR_NONE))
        else $error("error applied with injection off");

    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_beat_reg.drop == (out_beat_reg.applied_error == ERR_DROP)))
        else $error("drop flag disagrees with applied error");

endmodule

// ===== rtl/lfei_policy.sv =====
module lfei_policy
    import lfei_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic restart,
    input  cfg_t cfg,
    output logic fire
);

    logic [PER_W-1:0] phase_reg;
    logic [PER_W-1:0] phase_next;
    logic [CNT_W-1:0] flit_reg;
    logic [CNT_W-1:0] flit_next;

    logic [PER_W-1:0] phase_base;
    logic [PER_W:0]   phase_inc;
    logic [PER_W-1:0] period_eff;
    logic             periodic_hit;
    logic [CNT_W-1:0] flit_base;
    logic [CNT_W-1:0] flit_inc;
    logic             burst_hit;

    always_comb
    begin
        phase_base   = restart ? '0 : phase_reg;
        phase_inc    = {1'b0, phase_base} + {{PER_W{1'b0}}, 1'b1};
        period_eff   = (cfg.period == '0) ? PER_W'(1) : cfg.period;
        periodic_hit = (phase_inc >= {1'b0, period_eff});

        // saturating count
        flit_base = restart ? '0 : flit_reg;
        flit_inc  = (&flit_base) ? flit_base : flit_base + CNT_W'(1);
        burst_hit = (flit_inc >= cfg.win_open)
                    && ((flit_inc - cfg.win_open) < cfg.win_len);

        // restart clears both counters; only the selected one then advances
        phase_next = phase_base;
        flit_next  = flit_base;
        fire       = 1'b0;
        case (cfg.mode)
            MODE_PERIODIC:
            begin
                fire       = periodic_hit;
                phase_next = periodic_hit ? '0 : phase_inc[PER_W-1:0];
            end
            MODE_BURST:
            begin
                fire      = burst_hit;
                flit_next = flit_inc;
            end
            default:
            begin
                fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            flit_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            flit_reg  <= flit_next;
        end
    end

endmodule

// ===== rtl/lfei_apply.sv =====
module lfei_apply
    import lfei_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              fire,
    input  logic [KIND_W-1:0] error_kind,
    input  in_beat_t          beat,
    output out_beat_t         result
);

    logic [SEQ_W-1:0]  last_seq_reg;
    logic [KIND_W-1:0] applied;
    logic [SEQ_W:0]    seq_plus;
    logic [SEQ_W-1:0]  seq_wrap;

    always_comb
    begin
        applied  = (fire && (error_kind <= ERR_SKIP)) ? error_kind : ERR_NONE;
        seq_plus = {1'b0, beat.seq_in} + {{SEQ_W{1'b0}}, 1'b1};
        seq_wrap = SEQ_W'(seq_plus % SEQ_MODULUS);

        result.drop          = 1'b0;
        result.seq_out       = beat.seq_in;
        result.crc_out       = beat.crc_in;
        result.applied_error = applied;
        case (applied)
            ERR_CRC:  result.crc_out = beat.crc_in ^ CRC_INVERT;
            ERR_DROP: result.drop    = 1'b1;
            ERR_DUP:  result.seq_out = last_seq_reg;
            ERR_SKIP: result.seq_out = seq_wrap;
            default:  result.drop    = 1'b0;
        endcase
    end

    // duplicates replay without recording
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= '0;
        end
        else if (advance && (applied != ERR_DUP))
        begin
            last_seq_reg <= beat.seq_in;
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lfei_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned RANDOM_FLITS   = 1450;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned HOLD_PHASE     = 3;
    // mode 3 decodes as off, kinds above skip decode as none
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [KIND_W-1:0] ERR_BEYOND = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    lfei_in_if  flit_in_bus ();
    lfei_out_if flit_out_bus ();

    link_flit_error_injector u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .flit_in   (flit_in_bus),
        .flit_out  (flit_out_bus)
    );

    always #10 clk = ~clk;

    // shadow of the block's registers and policy state
    cfg_t             cfg_shadow;
    logic [CNT_W-1:0] pol_flit_count = '0;
    logic [PER_W-1:0] pol_phase = '0;
    logic [SEQ_W-1:0] last_seq_seen = '0;

    in_beat_t    flits_to_send[$];
    out_beat_t   injected_due[$];
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_hold_reqs = 0;

    function automatic out_beat_t apply_injection(in_beat_t f);
        out_beat_t         r;
        logic              fire;
        logic [PER_W:0]    next_phase;
        logic [PER_W-1:0]  eff_period;
        logic [KIND_W-1:0] kind;
        fire = 1'b0;
        kind = ERR_NONE;
        if (f.restart_count)
        begin
            pol_flit_count = '0;
            pol_phase = '0;
        end
        if (cfg_shadow.mode == MODE_PERIODIC)
        begin
            eff_period = (cfg_shadow.period == '0) ? PER_W'(1) : cfg_shadow.period;
            next_phase = {1'b0, pol_phase} + 1'b1;
            // also covers a period lowered below the current phase
            if (next_phase >= {1'b0, eff_period})
            begin
                pol_phase = '0;
                fire = 1'b1;
            end
            else
            begin
                pol_phase = next_phase[PER_W-1:0];
            end
        end
        else if (cfg_shadow.mode == MODE_BURST)
        begin
            if (pol_flit_count != '1)
                pol_flit_count = pol_flit_count + 1'b1;
            fire = (pol_flit_count >= cfg_shadow.win_open) &&
                   ((pol_flit_count - cfg_shadow.win_open) < cfg_shadow.win_len);
        end
        if (fire && cfg_shadow.error_kind <= ERR_SKIP)
            kind = cfg_shadow.error_kind;

        r.drop = (kind == ERR_DROP);
        r.crc_out = (kind == ERR_CRC) ? (f.crc_in ^ CRC_INVERT) : f.crc_in;
        r.applied_error = kind;
        if (kind == ERR_DUP)
        begin
            r.seq_out = last_seq_seen;
        end
        else
        begin
            if (kind == ERR_SKIP)
                r.seq_out = SEQ_W'((int'(f.seq_in) + 1) % SEQ_MODULUS);
            else
                r.seq_out = f.seq_in;
            last_seq_seen = f.seq_in;
        end
        return r;
    endfunction

    function automatic void check_result(out_beat_t got);
        out_beat_t want;
        if (injected_due.size() == 0)
        begin
            $error("unexpected result beat: seq_out %0d crc_out %h", got.seq_out, got.crc_out);
            err_count++;
            return;
        end
        want = injected_due.pop_front();
        if (got.drop !== want.drop)
        begin
            $error("drop: expected %0d, got %0d", want.drop, got.drop);
            err_count++;
        end
        if (got.seq_out !== want.seq_out)
        begin
            $error("seq_out: expected %0d, got %0d", want.seq_out, got.seq_out);
            err_count++;
        end
        if (got.crc_out !== want.crc_out)
        begin
            $error("crc_out: expected %h, got %h", want.crc_out, got.crc_out);
            err_count++;
        end
        if (got.applied_error !== want.applied_error)
        begin
            $error("applied_error: expected %0d, got %0d", want.applied_error,
                   got.applied_error);
            err_count++;
        end
    endfunction

    // mostly back-to-back, some short gaps, a few long ones, and calm stretches
    function automatic int unsigned idle_len(ref int unsigned calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if (r < 3)
            calm = $urandom_range(20, 80);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // sender
    in_beat_t    tx_flit;
    in_beat_t    tx_taken;
    int unsigned tx_gap = 0;
    int unsigned tx_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flit_in_bus.valid <= 1'b0;
            flit_in_bus.seq_in <= '0;
            flit_in_bus.crc_in <= '0;
            flit_in_bus.restart_count <= 1'b0;
        end
        else
        begin
            if (flit_in_bus.valid && flit_in_bus.ready)
            begin
                tx_taken.seq_in = flit_in_bus.seq_in;
                tx_taken.crc_in = flit_in_bus.crc_in;
                tx_taken.restart_count = flit_in_bus.restart_count;
                injected_due.push_back(apply_injection(tx_taken));
            end
            if (!flit_in_bus.valid || flit_in_bus.ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    flit_in_bus.valid <= 1'b0;
                end
                else if (flits_to_send.size() != 0)
                begin
                    tx_flit = flits_to_send.pop_front();
                    flit_in_bus.valid <= 1'b1;
                    flit_in_bus.seq_in <= tx_flit.seq_in;
                    flit_in_bus.crc_in <= tx_flit.crc_in;
                    flit_in_bus.restart_count <= tx_flit.restart_count;
                    tx_gap = idle_len(tx_calm);
                end
                else
                begin
                    flit_in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    out_beat_t   rx_got;
    int unsigned rx_stall = 0;
    int unsigned rx_calm = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_hold_served = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flit_out_bus.ready <= 1'b0;
        end
        else
        begin
            if (flit_out_bus.valid && flit_out_bus.ready)
            begin
                rx_got.drop = flit_out_bus.drop;
                rx_got.seq_out = flit_out_bus.seq_out;
                rx_got.crc_out = flit_out_bus.crc_out;
                rx_got.applied_error = flit_out_bus.applied_error;
                check_result(rx_got);
                rx_stall = idle_len(rx_calm);
            end
            if (rx_hold_served != rx_hold_reqs)
            begin
                rx_hold_served = rx_hold_reqs;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                flit_out_bus.ready <= 1'b0;
            end
            else if (rx_stall != 0)
            begin
                rx_stall--;
                flit_out_bus.ready <= 1'b0;
            end
            else
            begin
                flit_out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic cfg_t make_cfg(logic [MODE_W-1:0] mode, logic [KIND_W-1:0] kind,
                                      logic [PER_W-1:0] period, logic [CNT_W-1:0] start,
                                      logic [CNT_W-1:0] length);
        cfg_t c;
        c.mode = mode;
        c.error_kind = kind;
        c.period = period;
        c.win_open = start;
        c.win_len = length;
        return c;
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t        c;
        int unsigned r;
        r = $urandom_range(0, 99);
        c.mode = (r < 45) ? MODE_PERIODIC : (r < 85) ? MODE_BURST :
                 (r < 93) ? MODE_OFF : MODE_SPARE;
        if ($urandom_range(0, 99) < 85)
            c.error_kind = KIND_W'($urandom_range(ERR_CRC, ERR_SKIP));
        else
            c.error_kind = KIND_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        c.period = (r < 10) ? PER_W'(0) : (r < 18) ? '1 :
                   (r < 25) ? PER_W'($urandom) : PER_W'($urandom_range(1, 9));
        r = $urandom_range(0, 99);
        c.win_open = (r < 8) ? '1 : (r < 15) ? CNT_W'($urandom) :
                     CNT_W'($urandom_range(0, 40));
        r = $urandom_range(0, 99);
        c.win_len = (r < 10) ? '1 : (r < 15) ? CNT_W'(0) :
                    (r < 20) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 40));
        return c;
    endfunction

    function automatic void push_flit(logic [SEQ_W-1:0] seq, logic [CRC_W-1:0] crc,
                                      logic restart);
        in_beat_t f;
        f.seq_in = seq;
        f.crc_in = crc;
        f.restart_count = restart;
        flits_to_send.push_back(f);
    endfunction

    function automatic void push_rand_flit();
        push_flit(SEQ_W'($urandom_range(0, 511)), CRC_W'($urandom_range(0, 65535)),
                  $urandom_range(0, 99) < 4);
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // only called while the block is idle; entered and left on a rising edge
    task automatic program_cfg(cfg_t c);
        cfg_shadow = c;
        cfg_write(CFG_MODE, CFG_DATA_W'(c.mode));
        cfg_write(CFG_ERROR_KIND, CFG_DATA_W'(c.error_kind));
        cfg_write(CFG_PERIOD, CFG_DATA_W'(c.period));
        cfg_write(CFG_WIN_OPEN, c.win_open);
        cfg_write(CFG_WIN_LEN, c.win_len);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (flits_to_send.size() != 0 || flit_in_bus.valid || injected_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned chunk;
        int unsigned phase_no;
        flit_in_bus.valid = 1'b0;
        flit_in_bus.seq_in = '0;
        flit_in_bus.crc_in = '0;
        flit_in_bus.restart_count = 1'b0;
        flit_out_bus.ready = 1'b0;
        cfg_shadow = make_cfg(MODE_OFF, ERR_NONE, PER_W'(1), '0, '0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: injection off
        push_flit('0, '0, 1'b0);
        push_flit('1, '1, 1'b1);
        push_flit(SEQ_W'(255), CRC_W'(16'h00FF), 1'b0);
        wait_idle();

        // period zero acts as one
        program_cfg(make_cfg(MODE_PERIODIC, ERR_CRC, '0, '0, '0));
        push_flit(SEQ_W'(256), CRC_W'(16'hFF00), 1'b0);
        push_flit(SEQ_W'(1), CRC_W'(16'h1234), 1'b0);
        wait_idle();

        program_cfg(make_cfg(MODE_PERIODIC, ERR_DROP, PER_W'(3), '0, '0));
        repeat (4) push_rand_flit();
        wait_idle();

        // duplicate replays the last non-duplicate sequence
        program_cfg(make_cfg(MODE_PERIODIC, ERR_DUP, PER_W'(2), '0, '0));
        push_flit(SEQ_W'(17), '0, 1'b1);
        push_flit(SEQ_W'(40), '1, 1'b0);
        push_flit(SEQ_W'(99), '0, 1'b0);
        wait_idle();

        // skip wraps at the modulus
        program_cfg(make_cfg(MODE_PERIODIC, ERR_SKIP, PER_W'(1), '0, '0));
        push_flit('1, CRC_W'(16'hA5A5), 1'b0);
        push_flit('0, CRC_W'(16'h5A5A), 1'b0);
        wait_idle();

        program_cfg(make_cfg(MODE_SPARE, ERR_CRC, PER_W'(1), '0, '1));
        push_rand_flit();
        wait_idle();

        program_cfg(make_cfg(MODE_PERIODIC, ERR_BEYOND, PER_W'(1), '0, '0));
        push_rand_flit();
        wait_idle();

        program_cfg(make_cfg(MODE_PERIODIC, ERR_NONE, PER_W'(1), '0, '0));
        push_rand_flit();
        wait_idle();

        // phase reaches 5, then the period drops below it
        program_cfg(make_cfg(MODE_PERIODIC, ERR_CRC, PER_W'(8), '0, '0));
        push_flit(SEQ_W'(3), CRC_W'(16'h0F0F), 1'b1);
        repeat (4) push_rand_flit();
        wait_idle();
        program_cfg(make_cfg(MODE_PERIODIC, ERR_CRC, PER_W'(2), '0, '0));
        push_flit(SEQ_W'(4), CRC_W'(16'hF0F0), 1'b0);
        push_flit(SEQ_W'(5), CRC_W'(16'h0001), 1'b0);
        wait_idle();

        program_cfg(make_cfg(MODE_PERIODIC, ERR_CRC, '1, '0, '0));
        repeat (2) push_rand_flit();
        wait_idle();

        program_cfg(make_cfg(MODE_BURST, ERR_SKIP, '0, CNT_W'(2), CNT_W'(3)));
        push_flit(SEQ_W'(10), CRC_W'(16'h8000), 1'b1);
        repeat (5) push_rand_flit();
        wait_idle();

        // window end beyond 32 bits does not wrap
        program_cfg(make_cfg(MODE_BURST, ERR_DUP, '0, CNT_W'(3), '1));
        push_flit(SEQ_W'(77), CRC_W'(16'h7FFF), 1'b1);
        repeat (3) push_rand_flit();
        wait_idle();

        program_cfg(make_cfg(MODE_BURST, ERR_DROP, '0, '1, '1));
        push_rand_flit();
        wait_idle();

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_FLITS)
        begin
            program_cfg(rand_cfg());
            chunk = $urandom_range(30, 110);
            if (chunk > RANDOM_FLITS - sent)
                chunk = RANDOM_FLITS - sent;
            // receiver stalls long while the sender keeps offering
            if (phase_no == HOLD_PHASE)
                rx_hold_reqs++;
            repeat (chunk) push_rand_flit();
            sent += chunk;
            phase_no++;
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
